/* rtl/assert_macros.svh */
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be true on a rising clock edge outside reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* rtl/b64d_pkg.sv */
package b64d_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [16:0] CNT_MAX         = 17'h1FFFF;
    localparam logic [15:0] MAX_ENC_RESET   = 16'd4096;
    localparam logic [15:0] MAX_DEC_RESET   = 16'd3072;

    // configuration register indexes
    localparam logic [7:0] CFG_MAX_ENC = 8'd0;
    localparam logic [7:0] CFG_MAX_DEC = 8'd1;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_CHAR = 3'd1,
        ST_BAD_PAD  = 3'd2,
        ST_BAD_REM  = 3'd3,
        ST_TAIL     = 3'd4,
        ST_ENC_LONG = 3'd5,
        ST_DEC_LONG = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        CL_DATA = 2'd0,
        CL_PAD  = 2'd1,
        CL_BAD  = 2'd2
    } class_t;

    // one classified character, as it travels through the queue
    typedef struct packed {
        class_t     kind;
        logic [5:0] sextet;
        logic       last;
    } entry_t;

    function automatic entry_t classify(input logic [7:0] c, input logic last);
        entry_t e;
        e.kind   = CL_DATA;
        e.sextet = 6'd0;
        e.last   = last;
        if (c inside {["A":"Z"]}) begin
            e.sextet = 6'(c - 8'd65);
        end
        else if (c inside {["a":"z"]}) begin
            e.sextet = 6'(c - 8'd97 + 8'd26);
        end
        else if (c inside {["0":"9"]}) begin
            e.sextet = 6'(c - 8'd48 + 8'd52);
        end
        else if (c == "-") begin
            e.sextet = 6'd62;
        end
        else if (c == "_") begin
            e.sextet = 6'd63;
        end
        else if (c == "=") begin
            e.kind = CL_PAD;
        end
        else begin
            e.kind = CL_BAD;
        end
        return e;
    endfunction

endpackage

/* rtl/b64d_front.sv */
module b64d_front (
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] char_in
    input  logic                 s_axis_tlast,   // last_char
    input  logic                 q_full,
    output logic                 q_push,
    output b64d_pkg::entry_t     q_entry
);

    // map the character to its sextet or its class
    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;
    assign q_entry       = b64d_pkg::classify(s_axis_tdata, s_axis_tlast);

endmodule

/* rtl/b64d_queue.sv */
`include "assert_macros.svh"

module b64d_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  b64d_pkg::entry_t     push_entry,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output b64d_pkg::entry_t     head
);

    localparam int unsigned AW = b64d_pkg::QUEUE_AW;

    b64d_pkg::entry_t mem [b64d_pkg::QUEUE_DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;

    assign full      = (count_reg == (AW+1)'(b64d_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + AW'(push);
        rd_ptr_next = rd_ptr_reg + AW'(pop);
        count_next  = count_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `ASSERT_NEVER(a_no_overflow, push && full, "queue written while full")
    `ASSERT_NEVER(a_no_underflow, pop && !not_empty, "queue read while empty")
    `ASSERT_CLK(a_count_bound, count_reg <= (AW+1)'(b64d_pkg::QUEUE_DEPTH), "queue count too big")

endmodule

/* rtl/b64d_back.sv */
`include "assert_macros.svh"

module b64d_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [7:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 q_not_empty,
    input  b64d_pkg::entry_t     q_head,
    output logic                 q_pop,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [15:0]          m_axis_tdata,
    output logic                 m_axis_tuser,
    output logic                 m_axis_tlast
);

    logic [15:0]         max_enc_reg, max_dec_reg;
    logic [5:0]          buf_reg, buf_next;
    logic [2:0]          held_reg, held_next;
    logic [16:0]         cc_reg, cc_next;
    logic [16:0]         bc_reg, bc_next;
    logic [1:0]          pad_reg, pad_next;
    b64d_pkg::status_t   err_reg, err_next;

    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_byte_reg, out_byte_next;
    logic                out_bv_reg, out_bv_next;
    logic                out_last_reg, out_last_next;
    b64d_pkg::status_t   out_status_reg, out_status_next;

    assign q_pop         = q_not_empty && (!out_valid_reg || m_axis_tready);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_status_reg, out_byte_reg};
    assign m_axis_tuser  = out_bv_reg;
    assign m_axis_tlast  = out_last_reg;

    always_comb
    begin
        logic [5:0] v;
        logic [1:0] need;
        v               = q_head.sextet;
        need            = 2'd0;
        buf_next        = buf_reg;
        held_next       = held_reg;
        cc_next         = cc_reg;
        bc_next         = bc_reg;
        pad_next        = pad_reg;
        err_next        = err_reg;
        out_byte_next   = out_byte_reg;
        out_bv_next     = out_bv_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        out_valid_next  = m_axis_tready ? 1'b0 : out_valid_reg;

        if (q_pop)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = 8'd0;
            out_bv_next    = 1'b0;
            out_last_next  = q_head.last;
            if (cc_reg != b64d_pkg::CNT_MAX)
            begin
                cc_next = cc_reg + 17'd1;
            end

            if (err_reg == b64d_pkg::ST_OK)
            begin
                if (cc_next > {1'b0, max_enc_reg})
                begin
                    err_next = b64d_pkg::ST_ENC_LONG;
                end
                else if (q_head.kind == b64d_pkg::CL_PAD)
                begin
                    if (pad_reg >= 2'd2)
                    begin
                        err_next = b64d_pkg::ST_BAD_PAD;
                    end
                    else
                    begin
                        pad_next = pad_reg + 2'd1;
                    end
                end
                else if (pad_reg != 2'd0)
                begin
                    err_next = b64d_pkg::ST_BAD_PAD;
                end
                else if (q_head.kind == b64d_pkg::CL_BAD)
                begin
                    err_next = b64d_pkg::ST_BAD_CHAR;
                end
                else if (held_reg == 3'd0)
                begin
                    buf_next  = v;
                    held_next = 3'd6;
                end
                else
                begin
                    // complete a byte from the held bits and the top of this sextet
                    out_bv_next = 1'b1;
                    case (held_reg)
                        3'd2:
                        begin
                            out_byte_next = {buf_reg[1:0], v};
                            buf_next      = 6'd0;
                            held_next     = 3'd0;
                        end
                        3'd4:
                        begin
                            out_byte_next = {buf_reg[3:0], v[5:2]};
                            buf_next      = {4'd0, v[1:0]};
                            held_next     = 3'd2;
                        end
                        default:
                        begin
                            out_byte_next = {buf_reg, v[5:4]};
                            buf_next      = {2'd0, v[3:0]};
                            held_next     = 3'd4;
                        end
                    endcase
                    if (bc_reg != b64d_pkg::CNT_MAX)
                    begin
                        bc_next = bc_reg + 17'd1;
                    end
                    if (bc_next > {1'b0, max_dec_reg})
                    begin
                        err_next = b64d_pkg::ST_DEC_LONG;
                    end
                end
            end

            out_status_next = b64d_pkg::ST_OK;
            if (q_head.last)
            begin
                // end of string checks on the updated state
                if (held_next == 3'd4)
                begin
                    need = 2'd2;
                end
                else if (held_next == 3'd2)
                begin
                    need = 2'd1;
                end
                if (err_next == b64d_pkg::ST_OK)
                begin
                    if (held_next == 3'd6)
                    begin
                        err_next = b64d_pkg::ST_BAD_REM;
                    end
                    else if (pad_next != 2'd0 && pad_next != need)
                    begin
                        err_next = b64d_pkg::ST_BAD_PAD;
                    end
                    else if (held_next != 3'd0 && buf_next != 6'd0)
                    begin
                        err_next = b64d_pkg::ST_TAIL;
                    end
                end
                out_status_next = err_next;
                buf_next  = 6'd0;
                held_next = 3'd0;
                cc_next   = 17'd0;
                bc_next   = 17'd0;
                pad_next  = 2'd0;
                err_next  = b64d_pkg::ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_enc_reg <= b64d_pkg::MAX_ENC_RESET;
            max_dec_reg <= b64d_pkg::MAX_DEC_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == b64d_pkg::CFG_MAX_ENC)
            begin
                max_enc_reg <= cfg_data;
            end
            else if (cfg_index == b64d_pkg::CFG_MAX_DEC)
            begin
                max_dec_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg       <= '0;
            held_reg      <= '0;
            cc_reg        <= '0;
            bc_reg        <= '0;
            pad_reg       <= '0;
            err_reg       <= b64d_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            buf_reg       <= buf_next;
            held_reg      <= held_next;
            cc_reg        <= cc_next;
            bc_reg        <= bc_next;
            pad_reg       <= pad_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg   <= out_byte_next;
        out_bv_reg     <= out_bv_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
    end

    `ASSERT_CLK(a_held_even, held_reg[0] == 1'b0 && held_reg != 3'd7, "odd bit count held")
    `ASSERT_CLK(a_status_on_last, out_valid_reg && !out_last_reg |-> out_status_reg == b64d_pkg::ST_OK, "status before end of string")
    `ASSERT_CLK(a_byte_zero, out_valid_reg && !out_bv_reg |-> out_byte_reg == 8'd0, "byte set without byte_valid")
    `ASSERT_CLK(a_out_hold, out_valid_reg && !m_axis_tready |=> out_valid_reg && $stable(out_byte_reg), "output word lost under stall")

endmodule

/* rtl/base64url_strict_decoder.sv */
// a character word goes into the queue, then is decoded into the output register
// throughput: one character word per cycle unless the queue is full; the back end retires
// one queue entry a cycle unless the output stalls; input keeps flowing into the four-entry queue for four words
// reset: rst_n clears the queue, the per-string state and the output valid at once,
// and loads the limits with 4096 encoded characters and 3072 decoded bytes
module base64url_strict_decoder (
    input  logic        clk,
    input  logic        rst_n,

    // configuration writes, always accepted
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,      // 0 max_encoded_chars, 1 max_decoded_bytes
    input  logic [15:0] cfg_data,

    // encoded characters in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
    input  logic        s_axis_tlast,   // last_char

    // decoded words out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [10:8] status, [15:11] zero
    output logic        m_axis_tuser,   // byte_valid
    output logic        m_axis_tlast    // string_done
);

    // front to queue
    logic                 q_push;
    logic                 q_full;
    b64d_pkg::entry_t     q_in;

    // queue to back
    logic                 q_pop;
    logic                 q_not_empty;
    b64d_pkg::entry_t     q_head;

    // limits are to be rewritten only between strings by the user (unchecked here), so no backpressure is needed
    assign cfg_ready = 1'b1;

    // front: takes a character word and maps it to a sextet, a pad mark or a bad mark
    b64d_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_entry       (q_in)
    );

    // short queue decoupling the classifier from the decoder
    b64d_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    // back: bit packing, counting, padding rules, end checks and the output register
    b64d_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .q_not_empty   (q_not_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

/* tb/sv/b64d_checker.sv */
module b64d_checker (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
    input  logic        s_axis_tlast,   // last_char

    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // [7:0] data_byte, [10:8] status, [15:11] zero
    input  logic        m_axis_tuser,   // byte_valid
    input  logic        m_axis_tlast,   // string_done

    input  logic        drain_done,
    output int          mismatches,
    output int          outstanding,
    output int          words_checked
);

    localparam logic [7:0] PAD_CHAR    = "=";
    localparam int         PRINT_LIMIT = 40;

    typedef struct packed {
        logic [7:0]        data_byte;
        logic              byte_valid;
        logic              string_done;
        b64d_pkg::status_t status;
    } dec_word_t;

    // limits and per-string decode state
    logic [15:0]       lim_enc = b64d_pkg::MAX_ENC_RESET;
    logic [15:0]       lim_dec = b64d_pkg::MAX_DEC_RESET;
    logic [5:0]        acc_bits;
    logic [2:0]        acc_n;
    logic [16:0]       n_chars;
    logic [16:0]       n_bytes;
    logic [1:0]        n_pads;
    b64d_pkg::status_t err;

    dec_word_t   pending_words[$];
    int          fail_tally;
    int          seen_words;
    logic        leftovers_done;

    task automatic report(input string what);
        fail_tally++;
        if (fail_tally <= PRINT_LIMIT)
        begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
        begin
            report($sformatf("word %0d %s got %0d want %0d", seen_words, name, got, want));
        end
    endtask

    task automatic clear_string;
        acc_bits = '0;
        acc_n    = '0;
        n_chars  = '0;
        n_bytes  = '0;
        n_pads   = '0;
        err      = b64d_pkg::ST_OK;
    endtask

    // one character through the decoder, returning the word it causes
    task automatic decode_char(input logic [7:0] c, input logic fin, output dec_word_t w);
        int         v;
        int         h;
        logic [7:0] b;
        logic       got;
        logic [1:0] need;
        b   = '0;
        got = 1'b0;
        v   = -1;
        if (n_chars < b64d_pkg::CNT_MAX)
        begin
            n_chars++;
        end
        if (err == b64d_pkg::ST_OK)
        begin
            if (n_chars > lim_enc)
            begin
                err = b64d_pkg::ST_ENC_LONG;
            end
            else if (c == PAD_CHAR)
            begin
                if (n_pads >= 2'd2)
                begin
                    err = b64d_pkg::ST_BAD_PAD;
                end
                else
                begin
                    n_pads++;
                end
            end
            else if (n_pads != 0)
            begin
                err = b64d_pkg::ST_BAD_PAD;
            end
            else
            begin
                if (c >= "A" && c <= "Z")
                begin
                    v = int'(c) - int'("A");
                end
                else if (c >= "a" && c <= "z")
                begin
                    v = int'(c) - int'("a") + 26;
                end
                else if (c >= "0" && c <= "9")
                begin
                    v = int'(c) - int'("0") + 52;
                end
                else if (c == "-")
                begin
                    v = 62;
                end
                else if (c == "_")
                begin
                    v = 63;
                end
                if (v < 0)
                begin
                    err = b64d_pkg::ST_BAD_CHAR;
                end
                else if (acc_n == 0)
                begin
                    acc_bits = 6'(v);
                    acc_n    = 3'd6;
                end
                else
                begin
                    h        = int'(acc_n);
                    b        = 8'((int'(acc_bits) << (8 - h)) | (v >> (h - 2)));
                    got      = 1'b1;
                    acc_n    = 3'(h - 2);
                    acc_bits = 6'(v & ((1 << (h - 2)) - 1));
                    if (n_bytes < b64d_pkg::CNT_MAX)
                    begin
                        n_bytes++;
                    end
                    if (n_bytes > lim_dec)
                    begin
                        err = b64d_pkg::ST_DEC_LONG;
                    end
                end
            end
        end
        w.data_byte   = b;
        w.byte_valid  = got;
        w.string_done = fin;
        w.status      = b64d_pkg::ST_OK;
        if (fin)
        begin
            if (err == b64d_pkg::ST_OK)
            begin
                need = (acc_n == 3'd4) ? 2'd2 : (acc_n == 3'd2) ? 2'd1 : 2'd0;
                if (acc_n == 3'd6)
                begin
                    err = b64d_pkg::ST_BAD_REM;
                end
                else if (n_pads != 0 && n_pads != need)
                begin
                    err = b64d_pkg::ST_BAD_PAD;
                end
                else if (acc_n != 0 && acc_bits != 0)
                begin
                    err = b64d_pkg::ST_TAIL;
                end
            end
            w.status = err;
            clear_string();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        dec_word_t w;
        if (!rst_n)
        begin
            lim_enc = b64d_pkg::MAX_ENC_RESET;
            lim_dec = b64d_pkg::MAX_DEC_RESET;
            clear_string();
            pending_words.delete();
            fail_tally     = 0;
            seen_words     = 0;
            leftovers_done = 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == b64d_pkg::CFG_MAX_ENC)
                begin
                    lim_enc = cfg_data;
                end
                else if (cfg_index == b64d_pkg::CFG_MAX_DEC)
                begin
                    lim_dec = cfg_data;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                decode_char(s_axis_tdata, s_axis_tlast, w);
                pending_words = {pending_words, w};
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_words.size() == 0)
                begin
                    report($sformatf("unexpected result word %0h", m_axis_tdata));
                end
                else
                begin
                    w = pending_words.pop_front();
                    check_field("data_byte", m_axis_tdata[7:0], w.data_byte);
                    check_field("status", m_axis_tdata[10:8], w.status);
                    check_field("pad bits", m_axis_tdata[15:11], 0);
                    check_field("byte_valid", m_axis_tuser, w.byte_valid);
                    check_field("string_done", m_axis_tlast, w.string_done);
                end
                seen_words++;
            end
            if (drain_done && !leftovers_done)
            begin
                leftovers_done = 1'b1;
                if (pending_words.size() != 0)
                begin
                    report($sformatf("%0d result words never arrived", pending_words.size()));
                end
            end
        end
        mismatches    <= fail_tally;
        outstanding   <= pending_words.size();
        words_checked <= seen_words;
    end

endmodule

/* tb/sv/tb.sv */
module tb;

    localparam int         DRAIN_LIMIT    = 20000;
    localparam logic [7:0] CFG_UNUSED_TOP = 8'hFF;
    localparam logic [7:0] PAD_CHAR       = "=";

    // ways a well-formed string gets broken
    typedef enum int {
        MUT_SWAP,
        MUT_PAD_IN,
        MUT_PAD_EXTRA,
        MUT_DROP,
        MUT_TAIL
    } mutation_t;

    // receiver back-pressure patterns
    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_EVERY4,
        RX_SPARSE
    } stall_mode_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index     = '0;
    logic [15:0] cfg_data      = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // [7:0] char_in
    logic        s_axis_tlast  = 1'b0; // last_char
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // [7:0] data_byte, [10:8] status, [15:11] zero
    logic        m_axis_tuser;         // byte_valid
    logic        m_axis_tlast;         // string_done
    logic        drain_done    = 1'b0;

    int          mismatches;
    int          outstanding;
    int          words_checked;

    // stimulus bookkeeping
    logic [7:0]  line_buf[$];
    int          burst_left;
    int          chars_sent;
    int          strings_sent;
    int          settings_used;

    always #10 clk = ~clk;

    base64url_strict_decoder u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    b64d_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .drain_done    (drain_done),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .words_checked (words_checked)
    );

    // sextet value to its base64url character
    function automatic logic [7:0] char_of(input logic [5:0] sx);
        if (sx < 6'd26)
        begin
            return 8'("A" + sx);
        end
        else if (sx < 6'd52)
        begin
            return 8'("a" + sx - 6'd26);
        end
        else if (sx < 6'd62)
        begin
            return 8'("0" + sx - 6'd52);
        end
        else if (sx == 6'd62)
        begin
            return "-";
        end
        return "_";
    endfunction

    // add one character at the end of the line
    task automatic append_char(input logic [7:0] c);
        line_buf = {line_buf, c};
    endtask

    // one character word; a new burst may open with a gap, otherwise valid stays high
    task automatic send_word(input logic [7:0] c, input logic fin);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= fin;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        chars_sent++;
    endtask

    // whole string in line_buf, last flag on the final character
    task automatic send_line;
        for (int i = 0; i < line_buf.size(); i++)
        begin
            send_word(line_buf[i], i == line_buf.size() - 1);
        end
        strings_sent++;
    endtask

    task automatic send_text(input string s);
        line_buf.delete();
        for (int i = 0; i < s.len(); i++)
        begin
            append_char(s[i]);
        end
        send_line();
    endtask

    // mostly well-formed strings with random content, some broken, a few pure noise
    task automatic build_line;
        int         k;
        int         rem;
        int         pick;
        int         at;
        logic [5:0] sx;
        line_buf.delete();
        pick = $urandom_range(0, 99);
        if (pick < 6)
        begin
            repeat ($urandom_range(1, 6)) append_char(8'($urandom_range(0, 255)));
        end
        else
        begin
            // a few long strings push past the smaller limits
            k = ($urandom_range(0, 19) == 0) ? $urandom_range(2, 80) : $urandom_range(2, 14);
            if (k % 4 == 1)
            begin
                k++;
            end
            rem = k % 4;
            for (int i = 0; i < k; i++)
            begin
                sx = 6'($urandom_range(0, 63));
                // clean tail bits on the final data character
                if (i == k - 1 && rem == 2)
                begin
                    sx[3:0] = '0;
                end
                if (i == k - 1 && rem == 3)
                begin
                    sx[1:0] = '0;
                end
                append_char(char_of(sx));
            end
            // padding is optional but must match when present
            if (rem != 0 && $urandom_range(0, 1) == 1)
            begin
                repeat (4 - rem) append_char(PAD_CHAR);
            end
            if (pick >= 70)
            begin
                at = $urandom_range(0, line_buf.size() - 1);
                case (mutation_t'($urandom_range(0, 4)))
                    MUT_SWAP:      line_buf[at] = 8'($urandom_range(0, 255));
                    MUT_PAD_IN:    line_buf[at] = PAD_CHAR;
                    MUT_PAD_EXTRA: append_char(PAD_CHAR);
                    MUT_DROP:
                    begin
                        if (line_buf.size() > 1)
                        begin
                            line_buf.delete(line_buf.size() - 1);
                        end
                    end
                    default:
                    begin
                        // random final character, tail bits usually nonzero
                        line_buf[line_buf.size() - 1] = char_of(6'($urandom_range(0, 63)));
                    end
                endcase
            end
        end
    endtask

    task automatic run_random(input int n_chars);
        int stop_at;
        stop_at = chars_sent + n_chars;
        while (chars_sent < stop_at)
        begin
            build_line();
            send_line();
        end
    endtask

    // wait until every expected result word has come back
    task automatic wait_idle;
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // both limits, plus a write to an index that the block ignores
    task automatic set_limits(input logic [15:0] enc, input logic [15:0] dec);
        logic [7:0] junk;
        junk = ($urandom_range(0, 1) == 1) ? CFG_UNUSED_TOP : 8'($urandom_range(2, 254));
        write_reg(junk, 16'($urandom));
        write_reg(b64d_pkg::CFG_MAX_ENC, enc);
        write_reg(b64d_pkg::CFG_MAX_DEC, dec);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // receiver back-pressure, switching pattern every so often
    always @(posedge clk or negedge rst_n)
    begin
        static stall_mode_t mode      = RX_OPEN;
        static int          mode_left = 0;
        static int          tick      = 0;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            mode_left = 0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                mode      = stall_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            tick++;
            case (mode)
                RX_OPEN:   m_axis_tready <= 1'b1;
                RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                RX_EVERY4: m_axis_tready <= (tick % 4 == 0);
                default:   m_axis_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // hard stop in case the handshakes hang
    initial
    begin
        #10000000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        burst_left    = 0;
        chars_sent    = 0;
        strings_sent  = 0;
        settings_used = 1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed strings at the reset limits
        send_text("QQ==");   // remainder two, padded
        send_text("QUI=");   // remainder three, padded
        send_text("QR");     // leftover bits not zero
        send_text("Q");      // lone character, remainder one
        send_text("Q=Q");    // data after padding, error sticks
        send_text("QQ===");  // third pad
        line_buf.delete();
        append_char(8'hFF);
        send_line();
        line_buf.delete();
        append_char(8'h00);
        send_line();
        send_text("_-z9");   // top of the alphabet

        // limit extremes, then a zero limit that rejects everything
        wait_idle();
        set_limits(16'd1, 16'hFFFF);
        run_random(80);
        wait_idle();
        set_limits(16'hFFFF, 16'd1);
        run_random(80);
        wait_idle();
        set_limits(16'd0, 16'd0);
        run_random(40);
        wait_idle();
        set_limits(16'hFFFF, 16'hFFFF);
        run_random(300);

        // small random limits so length errors are frequent
        repeat (4)
        begin
            wait_idle();
            set_limits(16'($urandom_range(2, 24)), 16'($urandom_range(1, 16)));
            run_random(200);
        end
        wait_idle();
        set_limits(b64d_pkg::MAX_ENC_RESET, b64d_pkg::MAX_DEC_RESET);
        run_random(300);

        // drain, settle, then let the checker flag anything left over
        wait_idle();
        repeat (10) @(posedge clk);
        drain_done <= 1'b1;
        repeat (3) @(posedge clk);

        $display("sent %0d characters in %0d strings under %0d limit settings",
                 chars_sent, strings_sent, settings_used);
        $display("checked %0d result words, %0d mismatches", words_checked, mismatches);
        if (mismatches == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
